[rtl/core/ic3_pkg.sv]
package ic3_pkg;

  // Kernel geometry and coefficient format (signed Q8.8)
  localparam int KERNEL_SIZE = 3;
  localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 8;

  // Configuration port
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 48;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 12;

  // Result fields
  localparam int OUT_BITS     = 20;
  localparam int ROW_BITS     = 12;
  localparam int OUT_COL_BITS = 10;
  localparam int OUT_MAX      = 2 ** (OUT_BITS - 1) - 1;
  localparam int OUT_MIN      = -(2 ** (OUT_BITS - 1));

  // Results owed to the output before the input is held off
  localparam int FIFO_DEPTH = 8;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_COEF_TOP,
    REG_COEF_MIDDLE,
    REG_COEF_BOTTOM
  } reg_index_t;

  // Position of a window centre travelling alongside the pixel data
  typedef struct packed {
    logic                    emit;
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    last;
  } tag_t;

  // One result beat
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic [ROW_BITS-1:0]        row;
    logic [OUT_COL_BITS-1:0]    col;
    logic                       last;
  } result_t;

endpackage

[rtl/core/ic3_line_store.sv]
module ic3_line_store #(
  parameter int DEPTH      = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int AW         = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  output logic [ic3_pkg::KERNEL_TAPS-1:0][PIXEL_BITS-1:0] window
);

  localparam int KS = ic3_pkg::KERNEL_SIZE;

  // Each entry holds the older row above the newer row at one column
  logic [2*PIXEL_BITS-1:0] mem [DEPTH];
  logic [2*PIXEL_BITS-1:0] rd_data;

  logic                  s1_valid;
  logic [AW-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] s1_px;
  logic                  fwd;
  logic [PIXEL_BITS-1:0] fwd_older;
  logic [PIXEL_BITS-1:0] fwd_newer;
  logic [PIXEL_BITS-1:0] top_sel;
  logic [PIXEL_BITS-1:0] mid_sel;

  // Read the column as the pixel is accepted
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write back the shifted column in the cycle after the read
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_addr] <= {mid_sel, s1_px};
    end
  end

  // Forward the write data when a read hits the entry being written
  always_comb begin
    top_sel = fwd ? fwd_older : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    mid_sel = fwd ? fwd_newer : rd_data[PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      s1_valid <= rd_en;
      fwd      <= rd_en && s1_valid && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr <= rd_addr;
      s1_px   <= pixel_in;
    end
    if (s1_valid) begin
      fwd_older <= mid_sel;
      fwd_newer <= s1_px;
    end
  end

  // Shift the window left and take in the new column
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = 0; k < KS; k++) begin
        for (int j = 0; j < KS - 1; j++) begin
          window[k*KS+j] <= window[k*KS+j+1];
        end
      end
      window[KS-1]      <= top_sel;
      window[2*KS-1]    <= mid_sel;
      window[KS*KS-1]   <= s1_px;
    end
  end

endmodule

[rtl/core/ic3_mac.sv]
module ic3_mac #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ic3_pkg::KERNEL_TAPS-1:0][PIXEL_BITS-1:0]  window,
  input  logic [ic3_pkg::KERNEL_SIZE-1:0][ic3_pkg::CFG_DATA_BITS-1:0] coef_rows,
  input  ic3_pkg::tag_t         tag_in,
  output logic                  res_valid,
  output ic3_pkg::result_t      result
);

  localparam int KS = ic3_pkg::KERNEL_SIZE;
  localparam int CB = ic3_pkg::COEF_BITS;
  localparam int PW = PIXEL_BITS + CB + 1;
  localparam int RW = PW + 2;
  localparam int TW = RW + 2;
  localparam int QW = TW - ic3_pkg::FRAC_BITS;
  localparam logic signed [QW-1:0] Q_MAX = QW'(ic3_pkg::OUT_MAX);
  localparam logic signed [QW-1:0] Q_MIN = QW'(ic3_pkg::OUT_MIN);
  localparam logic signed [TW-1:0] ROUND = TW'(2 ** ic3_pkg::FRAC_BITS - 1);

  logic signed [PW-1:0] prod [ic3_pkg::KERNEL_TAPS];
  logic signed [RW-1:0] row_sum [KS];
  ic3_pkg::tag_t        tag_a;
  ic3_pkg::tag_t        tag_b;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] adj;
  logic signed [QW-1:0] quot;

  // Multiply each tap by its coefficient
  always_ff @(posedge clk) begin
    for (int k = 0; k < KS; k++) begin
      for (int j = 0; j < KS; j++) begin
        prod[k*KS+j] <= $signed({1'b0, window[k*KS+j]}) *
                        $signed(coef_rows[k][CB*j +: CB]);
      end
    end
  end

  // Add up each kernel row
  always_ff @(posedge clk) begin
    for (int k = 0; k < KS; k++) begin
      row_sum[k] <= RW'(prod[k*KS]) + RW'(prod[k*KS+1]) + RW'(prod[k*KS+2]);
    end
  end

  // Advance the position tag with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
    end else begin
      tag_a <= tag_in;
      tag_b <= tag_a;
    end
  end

  // Sum the rows, drop the fraction toward zero and saturate
  always_comb begin
    total = TW'(row_sum[0]) + TW'(row_sum[1]) + TW'(row_sum[2]);
    adj   = total[TW-1] ? total + ROUND : total;
    quot  = adj[TW-1:ic3_pkg::FRAC_BITS];
    if (quot > Q_MAX) begin
      result.value = ic3_pkg::OUT_BITS'(Q_MAX);
    end else if (quot < Q_MIN) begin
      result.value = ic3_pkg::OUT_BITS'(Q_MIN);
    end else begin
      result.value = quot[ic3_pkg::OUT_BITS-1:0];
    end
    result.row = tag_b.row;
    result.col = tag_b.col;
    result.last = tag_b.last;
    res_valid = tag_b.emit;
  end

endmodule

[rtl/core/ic3_out_fifo.sv]
module ic3_out_fifo #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ic3_pkg::result_t push_data,
  input  logic             pop_ready,
  output logic             pop_valid,
  output ic3_pkg::result_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ic3_pkg::result_t slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             pop;

  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/image_convolution_3x3.sv]
// 3x3 convolution over a raster-order grayscale stream. Pixels enter on the
// in_valid/in_ready channel, one per clock when the output keeps up; frame_start
// resets the position to row 0, column 0, and the position also wraps by
// itself after the last pixel of a frame. Each pixel at row >= 2 and column >= 2
// completes a window and yields one beat on the out_valid/out_ready channel: the
// kernel-weighted sum for the window centre (signed Q8.8 coefficients, fraction
// dropped toward zero, saturated to 20 bits), its row and column, and frame_last
// on the final interior result of the frame. The two previous rows live in one
// MAX_WIDTH-entry line memory that is read as a pixel is accepted and written
// back the cycle after, with forwarding when a new frame revisits a column still
// being written. A result passes the line memory read, window, product, row-sum
// and output queue registers; in_ready drops only while eight results are owed.
// The line memory needs no clearing pass. Write the registers only while idle.
module image_convolution_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ic3_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ic3_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [PIXEL_BITS-1:0]                 pixel,
  input  logic                                  frame_start,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ic3_pkg::OUT_BITS-1:0]   filtered_value,
  output logic [ic3_pkg::ROW_BITS-1:0]          centre_row,
  output logic [ic3_pkg::OUT_COL_BITS-1:0]      centre_col,
  output logic                                  frame_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = (CW + 1 > ic3_pkg::WIDTH_REG_BITS) ? CW + 1 : ic3_pkg::WIDTH_REG_BITS;
  localparam int RB  = ic3_pkg::ROW_BITS;
  localparam int CRW = $clog2(ic3_pkg::FIFO_DEPTH + 1);

  // Configuration registers
  logic [ic3_pkg::WIDTH_REG_BITS-1:0]  image_width;
  logic [ic3_pkg::HEIGHT_REG_BITS-1:0] image_height;
  logic [ic3_pkg::KERNEL_SIZE-1:0][ic3_pkg::CFG_DATA_BITS-1:0] coef_rows;

  logic [EW-1:0]     width_ext;
  logic [EW-1:0]     width_eff;
  logic [CW-1:0]     w_last;
  logic [RB-1:0]     h_last;

  logic [RB-1:0]     row_count;
  logic [CW-1:0]     col_count;
  logic [RB-1:0]     row_now;
  logic [CW-1:0]     col_now;
  logic [RB-1:0]     row_count_next;
  logic [CW-1:0]     col_count_next;
  logic              acc;
  logic              emit_now;
  ic3_pkg::tag_t     tag_now;
  ic3_pkg::tag_t     tag1;
  logic              valid1;
  ic3_pkg::tag_t     tag2;

  logic [CRW-1:0]    credit;
  logic              pop;

  logic [ic3_pkg::KERNEL_TAPS-1:0][PIXEL_BITS-1:0] window;
  logic              res_valid;
  ic3_pkg::result_t  result;
  ic3_pkg::result_t  out_beat;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ic3_pkg::WIDTH_REG_BITS'(1024);
      image_height <= ic3_pkg::HEIGHT_REG_BITS'(4095);
      coef_rows[0] <= '0;
      coef_rows[1] <= 48'h0000_0100_0000;
      coef_rows[2] <= '0;
    end else if (cfg_we) begin
      unique case (ic3_pkg::reg_index_t'(cfg_index))
        ic3_pkg::REG_IMAGE_WIDTH:
          image_width <= cfg_data[ic3_pkg::WIDTH_REG_BITS-1:0];
        ic3_pkg::REG_IMAGE_HEIGHT:
          image_height <= cfg_data[ic3_pkg::HEIGHT_REG_BITS-1:0];
        ic3_pkg::REG_COEF_TOP:    coef_rows[0] <= cfg_data;
        ic3_pkg::REG_COEF_MIDDLE: coef_rows[1] <= cfg_data;
        ic3_pkg::REG_COEF_BOTTOM: coef_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame width to between 3 and what the line memory holds, and the height to at least 3
  always_comb begin
    width_ext = EW'(image_width);
    if (width_ext < EW'(3)) begin
      width_eff = EW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    w_last = CW'(width_eff - EW'(1));
    h_last = (image_height < RB'(3)) ? RB'(2) : image_height - RB'(1);
  end

  // Position of the accepted pixel and of its window centre
  always_comb begin
    acc      = in_valid && in_ready;
    row_now  = frame_start ? '0 : row_count;
    col_now  = frame_start ? '0 : col_count;
    emit_now = (row_now >= RB'(2)) && (col_now >= CW'(2));
    tag_now.emit = emit_now;
    tag_now.row  = row_now - RB'(1);
    tag_now.col  = ic3_pkg::OUT_COL_BITS'(col_now - CW'(1));
    tag_now.last = (row_now >= h_last) && (col_now >= w_last);
    if (col_now >= w_last) begin
      col_count_next = '0;
      row_count_next = (row_now >= h_last) ? '0 : row_now + RB'(1);
    end else begin
      col_count_next = col_now + CW'(1);
      row_count_next = row_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Carry the tag beside the line memory read and window update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      tag2   <= '0;
    end else begin
      valid1 <= acc;
      tag2   <= '{emit: valid1 && tag1.emit, row: tag1.row, col: tag1.col,
                  last: tag1.last};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tag1 <= tag_now;
    end
  end

  // Count results owed to the output; hold the input when the queue could fill
  assign pop      = out_valid && out_ready;
  assign in_ready = (credit < CRW'(ic3_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({acc && emit_now, pop})
        2'b10:   credit <= credit + CRW'(1);
        2'b01:   credit <= credit - CRW'(1);
        default: credit <= credit;
      endcase
    end
  end

  ic3_line_store #(
    .DEPTH      (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (CW)
  ) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (acc),
    .rd_addr  (col_now),
    .pixel_in (pixel),
    .window   (window)
  );

  ic3_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .coef_rows (coef_rows),
    .tag_in    (tag2),
    .res_valid (res_valid),
    .result    (result)
  );

  ic3_out_fifo #(
    .DEPTH (ic3_pkg::FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (result),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (out_beat)
  );

  assign filtered_value = out_beat.value;
  assign centre_row     = out_beat.row;
  assign centre_col     = out_beat.col;
  assign frame_last     = out_beat.last;

  // Owed results never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CRW'(ic3_pkg::FIFO_DEPTH))
    else $error("result credit beyond queue depth");

  // A window-completing pixel reaches the queue after the read, window, product and row-sum registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (acc && emit_now) |-> ##4 res_valid)
    else $error("result missing at queue input");

  // The last column of a row wraps the column count
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && (col_now >= w_last)) |=> (col_count == '0))
    else $error("column count did not wrap");

  // A beat on offer is always one that is owed
  a_out_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (credit != '0))
    else $error("output beat without credit");

endmodule
